FILE: src/fqrp_pkg.sv
// Package for the FASTQ record parser: word types, result kinds, phases
// and counter limits. No dependencies.
package fqrp_pkg;

  localparam int LINE_COUNT_MAX = 255;
  localparam int LENGTH_WIDTH   = 24;

  localparam int LEN_W  = 24;
  localparam int LINE_W = 8;

  localparam int LINE_LIMIT_I = (LINE_COUNT_MAX > 255) ? 255 : LINE_COUNT_MAX;
  localparam longint LEN_LIMIT_RAW = (longint'(1) << LENGTH_WIDTH) - 1;
  localparam longint LEN_LIMIT_L =
      (LEN_LIMIT_RAW > longint'(16777215)) ? longint'(16777215) : LEN_LIMIT_RAW;

  localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(LINE_LIMIT_I);
  localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(LEN_LIMIT_L);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_SEQ     = 3'd1,
    KIND_QUAL    = 3'd2,
    KIND_REC_END = 3'd3,
    KIND_TRUNC   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SEQ    = 2'd1,
    PH_SPACER = 2'd2,
    PH_QUAL   = 2'd3
  } phase_t;

  typedef enum logic [0:0] {
    REG_MIN_LEN = 1'b0,
    REG_MAX_LEN = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       result_kind;
    logic [7:0]       char_value;
    logic [LEN_W-1:0] read_length;
    logic             length_pass;
    logic             last_result;
  } out_word_t;

  // one accepted byte, as classified by the front end
  typedef struct packed {
    logic             has_char;
    logic [2:0]       char_kind;
    logic [7:0]       char_value;
    logic             has_end;
    logic [2:0]       end_kind;
    logic [LEN_W-1:0] read_length;
    logic             length_pass;
  } cmd_t;

endpackage

FILE: src/fqrp_front.sv
// Front end: phase tracking, counters and length registers; turns each
// accepted byte into a command word. Depends on fqrp_pkg.
module fqrp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  fqrp_pkg::in_word_t item,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [23:0]       cfg_data,
  output logic              cmd_push,
  output fqrp_pkg::cmd_t    cmd
);
  import fqrp_pkg::*;

  phase_t            phase, phase_next, step_phase;
  logic              at_header_start, at_header_start_next, step_ahs;
  logic [LINE_W-1:0] line_count, line_count_next, step_lc, lc_dec;
  logic [LEN_W-1:0]  length_count, length_count_next, step_len;
  logic [LEN_W-1:0]  min_read_length, max_read_length;
  logic              step_end, eoi_end, eoi_err;
  logic              kept, is_nl, is_plus;

  assign kept    = item.byte_value > CH_SPACE;
  assign is_nl   = item.byte_value == CH_NEWLINE;
  assign is_plus = item.byte_value == CH_PLUS;
  assign lc_dec  = (line_count != '0) ? line_count - LINE_W'(1) : line_count;

  always_comb begin
    step_phase = phase;
    step_ahs   = at_header_start;
    step_lc    = line_count;
    step_len   = length_count;
    step_end   = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        if (at_header_start) begin
          if (kept) step_ahs = 1'b0;
        end else if (is_nl) begin
          step_phase = PH_SEQ;
          step_lc    = '0;
          step_len   = '0;
        end
      end
      PH_SEQ: begin
        if (is_plus) begin
          step_phase = PH_SPACER;
        end else begin
          if (is_nl && line_count < LINE_LIMIT) step_lc = line_count + LINE_W'(1);
          if (kept && length_count < LEN_LIMIT) step_len = length_count + LEN_W'(1);
        end
      end
      PH_SPACER: begin
        if (is_nl) begin
          if (line_count == '0) step_end = 1'b1;
          else step_phase = PH_QUAL;
        end
      end
      PH_QUAL: begin
        if (is_nl) begin
          if (lc_dec == '0) step_end = 1'b1;
          else step_lc = lc_dec;
        end
      end
      default: ;
    endcase
    if (step_end) begin
      step_phase = PH_HEADER;
      step_ahs   = 1'b1;
      step_lc    = '0;
      step_len   = '0;
    end

    eoi_end = 1'b0;
    eoi_err = 1'b0;
    if (item.end_of_input) begin
      if (step_phase == PH_QUAL && step_lc <= LINE_W'(1)) eoi_end = 1'b1;
      else if (step_phase != PH_HEADER || !step_ahs) eoi_err = 1'b1;
    end

    phase_next           = step_phase;
    at_header_start_next = step_ahs;
    line_count_next      = step_lc;
    length_count_next    = step_len;
    if (eoi_end || eoi_err) begin
      phase_next           = PH_HEADER;
      at_header_start_next = 1'b1;
      line_count_next      = '0;
      length_count_next    = '0;
    end
  end

  always_comb begin
    cmd = '0;
    unique case (phase)
      PH_HEADER: begin
        cmd.has_char  = !at_header_start && !is_nl && kept;
        cmd.char_kind = KIND_HEADER;
      end
      PH_SEQ: begin
        cmd.has_char  = !is_plus && kept;
        cmd.char_kind = KIND_SEQ;
      end
      PH_SPACER: begin
        cmd.has_char  = 1'b0;
        cmd.char_kind = KIND_HEADER;
      end
      PH_QUAL: begin
        cmd.has_char  = kept;
        cmd.char_kind = KIND_QUAL;
      end
      default: ;
    endcase
    cmd.char_value = item.byte_value;
    cmd.has_end    = step_end || eoi_end || eoi_err;
    cmd.end_kind   = (step_end || eoi_end) ? KIND_REC_END : KIND_TRUNC;
    if (step_end || eoi_end) begin
      cmd.read_length = length_count;
      cmd.length_pass = (length_count >= min_read_length) &&
                        (max_read_length == '0 || length_count <= max_read_length);
    end
    cmd_push = accept && (cmd.has_char || cmd.has_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      at_header_start <= 1'b1;
      line_count      <= '0;
      length_count    <= '0;
      min_read_length <= '0;
      max_read_length <= '0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        at_header_start <= at_header_start_next;
        line_count      <= line_count_next;
        length_count    <= length_count_next;
      end
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_MIN_LEN: min_read_length <= cfg_data;
          REG_MAX_LEN: max_read_length <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: src/fqrp_cmdq.sv
// Short command queue between front and back end.
// Depends on fqrp_pkg.
module fqrp_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fqrp_pkg::cmd_t push_word,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output fqrp_pkg::cmd_t head
);
  import fqrp_pkg::*;

  cmd_t              entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr, rd_ptr;
  logic [CMDQ_AW:0]   count;
  logic               do_push, do_pop;

  assign full    = count == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + CMDQ_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + CMDQ_AW'(1);
      if (do_push && !do_pop)      count <= count + (CMDQ_AW+1)'(1);
      else if (do_pop && !do_push) count <= count - (CMDQ_AW+1)'(1);
    end
  end

endmodule

FILE: src/fqrp_back.sv
// Back end: expands each command into one or two result words and holds
// the oldest one in the output register. Depends on fqrp_pkg.
module fqrp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  fqrp_pkg::cmd_t    q_head,
  output logic              q_pop,
  input  logic              pop,
  output logic              out_valid,
  output fqrp_pkg::out_word_t out_word
);
  import fqrp_pkg::*;

  logic      sent_first, sent_first_next;
  logic      load;
  out_word_t word_next;

  assign load = !q_empty && (!out_valid || pop);

  always_comb begin
    word_next       = '0;
    sent_first_next = sent_first;
    q_pop           = 1'b0;
    if (q_head.has_char && !sent_first) begin
      word_next.result_kind = q_head.char_kind;
      word_next.char_value  = q_head.char_value;
      word_next.last_result = !q_head.has_end;
      if (load) begin
        if (q_head.has_end) sent_first_next = 1'b1;
        else q_pop = 1'b1;
      end
    end else begin
      word_next.result_kind = q_head.end_kind;
      word_next.read_length = q_head.read_length;
      word_next.length_pass = q_head.length_pass;
      word_next.last_result = 1'b1;
      if (load) begin
        sent_first_next = 1'b0;
        q_pop           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_word <= word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      sent_first <= 1'b0;
    end else begin
      sent_first <= sent_first_next;
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  a_pending_pair: assert property (@(posedge clk) disable iff (rst)
    sent_first |-> (!q_empty && q_head.has_char && q_head.has_end))
    else $error("second half pending without a two-word command");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_word.result_kind == KIND_REC_END ||
                   out_word.result_kind == KIND_TRUNC)) |-> out_word.last_result)
    else $error("record end or error word not marked last");

  a_notlast_is_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.last_result) |->
      (out_word.result_kind == KIND_HEADER || out_word.result_kind == KIND_SEQ ||
       out_word.result_kind == KIND_QUAL))
    else $error("non-final word is not a character");

  a_end_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.result_kind == KIND_TRUNC) |->
      (out_word.read_length == '0 && !out_word.length_pass && out_word.char_value == '0))
    else $error("truncation word carries data");

endmodule

FILE: src/fastq_record_parser.sv
// FASTQ record parser top level: one byte word in per cycle while the queue is not full, results out.
// Path: each byte's command is written to the command queue, then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; a byte with two results holds the back end
// for an extra output word, absorbed by a four-entry command queue.
// Reset (rst, synchronous): header phase, counters and length registers zero.
// Depends on fqrp_pkg, fqrp_front, fqrp_cmdq, fqrp_back.
module fastq_record_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  fqrp_pkg::in_word_t  item,
  output logic                empty,
  input  logic                pop,
  output fqrp_pkg::out_word_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data
);
  import fqrp_pkg::*;

  logic      accept, cmd_push, q_full, q_empty, q_pop, out_valid;
  cmd_t      cmd, q_head;

  assign full      = q_full;
  assign accept    = push && !q_full;
  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  fqrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  fqrp_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_word (cmd),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  fqrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (result)
  );

endmodule

FILE: tb/tb_fastq_record_parser.sv
// Testbench for fastq_record_parser: directed byte table, then random FASTQ records
// and noise under several length-bound and idle/stall settings, checked word by word.
// Depends on fqrp_pkg and the fastq_record_parser RTL.
`timescale 1ns / 100ps

module tb;
  import fqrp_pkg::*;

  typedef struct packed {
    in_word_t  w;
    logic      pinned;
    out_word_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_word_t    item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_word_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;

  // parser image
  phase_t      ph = PH_HEADER;
  logic        at_start = 1'b1;
  logic [7:0]  lines = '0;
  logic [23:0] seq_len = '0;
  logic [23:0] min_len = '0;
  logic [23:0] max_len = '0;

  out_word_t   pending_results [$];
  int          fail_count = 0;
  int          bytes_in = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  row_t        plan [26];

  fastq_record_parser uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_word_t mk_word(input kind_t k, input logic [7:0] ch,
                                        input logic [23:0] len, input logic pass);
    out_word_t w;
    w = '0;
    w.result_kind = k;
    w.char_value = ch;
    w.read_length = len;
    w.length_pass = pass;
    return w;
  endfunction

  function automatic void rewind();
    ph = PH_HEADER;
    at_start = 1'b1;
    lines = '0;
    seq_len = '0;
  endfunction

  function automatic out_word_t close_record();
    out_word_t w;
    w = mk_word(KIND_REC_END, 8'h00, seq_len,
                (seq_len >= min_len) && (max_len == '0 || seq_len <= max_len));
    rewind();
    return w;
  endfunction

  function automatic int parse_byte(input logic [7:0] b, input logic eoi,
                                    output out_word_t res [2]);
    logic kept;
    int   n;
    kept = b > CH_SPACE;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    case (ph)
      PH_HEADER: begin
        if (at_start) begin
          if (kept) at_start = 1'b0;
        end else if (b == CH_NEWLINE) begin
          ph = PH_SEQ;
          lines = '0;
          seq_len = '0;
        end else if (kept) begin
          res[n] = mk_word(KIND_HEADER, b, '0, 1'b0);
          n++;
        end
      end
      PH_SEQ: begin
        if (b == CH_PLUS) begin
          ph = PH_SPACER;
        end else begin
          if (b == CH_NEWLINE && lines < LINE_LIMIT) lines++;
          if (kept) begin
            res[n] = mk_word(KIND_SEQ, b, '0, 1'b0);
            n++;
            if (seq_len < LEN_LIMIT) seq_len++;
          end
        end
      end
      PH_SPACER: begin
        if (b == CH_NEWLINE) begin
          if (lines == '0) begin
            res[n] = close_record();
            n++;
          end else begin
            ph = PH_QUAL;
          end
        end
      end
      default: begin
        if (kept) begin
          res[n] = mk_word(KIND_QUAL, b, '0, 1'b0);
          n++;
        end
        if (b == CH_NEWLINE) begin
          if (lines > '0) lines--;
          if (lines == '0) begin
            res[n] = close_record();
            n++;
          end
        end
      end
    endcase
    if (eoi) begin
      if (ph == PH_QUAL && lines <= 8'd1) begin
        res[n] = close_record();
        n++;
      end else if (ph != PH_HEADER || !at_start) begin
        res[n] = mk_word(KIND_TRUNC, 8'h00, '0, 1'b0);
        n++;
        rewind();
      end
    end
    if (n > 0) res[n-1].last_result = 1'b1;
    return n;
  endfunction

  function automatic row_t row(input logic [7:0] b, input logic e);
    row_t r;
    r = '0;
    r.w = {b, e};
    return r;
  endfunction

  function automatic row_t pin(input logic [7:0] b, input logic e, input kind_t k,
                               input logic [7:0] ch, input logic [23:0] len,
                               input logic pass);
    row_t r;
    r = row(b, e);
    r.pinned = 1'b1;
    r.want = mk_word(k, ch, len, pass);
    r.want.last_result = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] txt(input bit plus_ok);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_NEWLINE || (!plus_ok && b == CH_PLUS));
    return b;
  endfunction

  task automatic feed(input logic [7:0] b, input logic e, input logic pinned,
                      input out_word_t want);
    out_word_t fresh [2];
    int        n;
    int        k;
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= {b, e};
    @(posedge clk);
    while (full) @(posedge clk);
    n = parse_byte(b, e, fresh);
    bytes_in++;
    if (pinned) begin
      pending_results.push_back(want);
    end else begin
      for (k = 0; k < n; k++) pending_results.push_back(fresh[k]);
    end
  endtask

  // hold the sender until every expected word is out, then let in-flight bytes settle
  task automatic await_idle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_bounds(input logic [23:0] lo, input logic [23:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MIN_LEN;
    cfg_data <= lo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_len = lo;
    cfg_index <= REG_MAX_LEN;
    cfg_data <= hi;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_len = hi;
    cfg_valid <= 1'b0;
  endtask

  // forced_lines >= 0 gives that many empty sequence and quality lines
  task automatic send_record(input int forced_lines);
    logic [7:0] rec [$];
    int         nl;
    int         width;
    int         mode;
    int         last;
    int         i;
    repeat ($urandom_range(0, 2)) rec.push_back(8'($urandom_range(0, 32)));
    rec.push_back(8'($urandom_range(33, 255)));
    repeat ($urandom_range(0, 6)) rec.push_back(txt(1'b1));
    rec.push_back(CH_NEWLINE);
    if (forced_lines >= 0) nl = forced_lines;
    else nl = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    width = (forced_lines >= 0) ? 0 : 10;
    if (nl == 0) repeat ($urandom_range(0, 8)) rec.push_back(txt(1'b0));
    repeat (nl) begin
      repeat ($urandom_range(0, width)) rec.push_back(txt(1'b0));
      rec.push_back(CH_NEWLINE);
    end
    rec.push_back(CH_PLUS);
    repeat ($urandom_range(0, 3)) rec.push_back(txt(1'b1));
    rec.push_back(CH_NEWLINE);
    repeat (nl) begin
      repeat ($urandom_range(0, width)) rec.push_back(txt(1'b1));
      rec.push_back(CH_NEWLINE);
    end
    mode = $urandom_range(0, 99);
    last = rec.size() - 1;
    if (mode >= 88) last = $urandom_range(0, rec.size() - 1);
    for (i = 0; i <= last; i++) feed(rec[i], (mode >= 78) && (i == last), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(input string name, input logic [23:0] want_v,
                             input logic [23:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, expected none, got %h", $time, result);
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 24'(want.result_kind), 24'(result.result_kind));
        check_field("char_value", 24'(want.char_value), 24'(result.char_value));
        check_field("read_length", want.read_length, result.read_length);
        check_field("length_pass", 24'(want.length_pass), 24'(result.length_pass));
        check_field("last_result", 24'(want.last_result), 24'(result.last_result));
      end
    end
  end

  initial begin
    int          p;
    int          i;
    int          target;
    int          phase_start;
    bit          paused;
    int          gap_of [6];
    int          stall_of [6];
    logic [23:0] lo_of [6];
    logic [23:0] hi_of [6];
    plan = '{
      row(CH_SPACE, 1'b0),                                  // blank before header
      row("@", 1'b0),
      pin(8'h21, 1'b0, KIND_HEADER, 8'h21, '0, 1'b0),
      pin(8'hFF, 1'b0, KIND_HEADER, 8'hFF, '0, 1'b0),
      row(CH_NEWLINE, 1'b0),
      row("A", 1'b0),
      row(CH_NEWLINE, 1'b0),
      row("C", 1'b0),
      row(CH_PLUS, 1'b0),
      row(CH_NEWLINE, 1'b0),
      row("I", 1'b0),
      pin(CH_NEWLINE, 1'b0, KIND_REC_END, 8'h00, 24'd2, 1'b1),
      row("@", 1'b0),
      row(CH_NEWLINE, 1'b0),
      row(CH_PLUS, 1'b0),
      pin(CH_NEWLINE, 1'b0, KIND_REC_END, 8'h00, 24'd0, 1'b1), // spacer ends record
      row("@", 1'b0),
      pin(8'h00, 1'b1, KIND_TRUNC, 8'h00, '0, 1'b0),
      row(8'h00, 1'b1),                                     // eoi at clean header start
      row(">", 1'b0),
      row(CH_NEWLINE, 1'b0),
      row("G", 1'b0),
      row(CH_NEWLINE, 1'b0),
      row(CH_PLUS, 1'b0),
      row(CH_NEWLINE, 1'b0),
      row("J", 1'b1)                                        // eoi on last quality line
    };
    gap_of = '{0, 45, 0, 32, 0, 32};
    stall_of = '{0, 0, 45, 32, 0, 32};
    lo_of = '{24'd0, 24'd3, 24'hFFFFFF, 24'd0, 24'd5, 24'($urandom_range(0, 8))};
    hi_of = '{24'd0, 24'd10, 24'd0, 24'hFFFFFF, 24'd5, 24'($urandom_range(0, 15))};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < 26; i++) feed(plan[i].w.byte_value, plan[i].w.end_of_input,
                                  plan[i].pinned, plan[i].want);
    await_idle();
    for (p = 0; p < 6; p++) begin
      program_bounds(lo_of[p], hi_of[p]);
      gap_pct = gap_of[p];
      stall_pct = stall_of[p];
      target = 26 + (p + 1) * 312;
      phase_start = bytes_in;
      paused = 1'b0;
      if (p == 4) send_record(260);                         // line count saturation
      while (bytes_in < target) begin
        if ($urandom_range(0, 14) == 0) begin
          repeat ($urandom_range(1, 4))
            feed(8'($urandom), $urandom_range(0, 7) == 0, 1'b0, '0);
        end else begin
          send_record(-1);
        end
        if (!paused && bytes_in - phase_start > 150) begin
          await_idle();
          paused = 1'b1;
        end
      end
      await_idle();
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
